// ----- hw/rtl/lcbcl_pkg.sv -----
// Shared types, constants and helpers for the last-character chained lookup table.
`default_nettype none

package lcbcl_pkg;

	// Table geometry
	localparam int ENTRIES = 256;
	localparam int IDX_W   = $clog2(ENTRIES);
	localparam int CNT_W   = IDX_W + 1;
	localparam int BUCKETS = 256;
	localparam int BKT_W   = 8;
	localparam int KEY_W   = 32;

	// Command codes
	localparam logic [1:0] CMD_INSERT = 2'd0;
	localparam logic [1:0] CMD_LOOKUP = 2'd1;
	localparam logic [1:0] CMD_CLEAR  = 2'd2;

	// Result status codes
	localparam logic [2:0] ST_INSERTED  = 3'd0;
	localparam logic [2:0] ST_FULL      = 3'd1;
	localparam logic [2:0] ST_FOUND     = 3'd2;
	localparam logic [2:0] ST_NOT_FOUND = 3'd3;
	localparam logic [2:0] ST_CLEARED   = 3'd4;

	typedef struct packed {
		logic [1:0]       cmd;
		logic [KEY_W-1:0] key;
	} req_t;

	typedef struct packed {
		logic [2:0] status;
		logic [7:0] entry_index;
		logic [8:0] probe_count;
	} rsp_t;

	// Controller to datapath commands
	typedef struct packed {
		logic       latch;
		logic       rd_bucket;
		logic       ins_write;
		logic       clr;
		logic       lk_start;
		logic       lk_step;
		logic       finish;
		logic       walk_done;
		logic [2:0] result;
	} dp_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic [1:0] cmd;
		logic       full;
		logic       used;
		logic       match;
		logic       last;
		logic       out_free;
	} dp_stat_t;

	// Fit an entry index into the 8-bit result field
	function automatic logic [7:0] to_index8(input logic [IDX_W-1:0] idx);
		logic [IDX_W+7:0] ext;
		ext = {8'b0, idx};
		return ext[7:0];
	endfunction

	// Fit a probe count into the 9-bit result field
	function automatic logic [8:0] to_probe9(input logic [CNT_W-1:0] cnt);
		logic [CNT_W+8:0] ext;
		ext = {9'b0, cnt};
		return ext[8:0];
	endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/lcbcl_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module lcbcl_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read port, data held until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/lcbcl_ctrl.sv -----
// Controller state machine sequencing insert, lookup and clear operations.
`default_nettype none

module lcbcl_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               req_valid,
	output logic                    req_ready,
	input  wire lcbcl_pkg::dp_stat_t stat,
	output lcbcl_pkg::dp_cmd_t      cmd
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_DISP   = 3'd1;
	localparam logic [2:0] S_INS_WR = 3'd2;
	localparam logic [2:0] S_LK_HD  = 3'd3;
	localparam logic [2:0] S_LK_CMP = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign req_ready = (state_q == S_IDLE);

	// Decode state and status into datapath commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.latch = 1'b1;
					state_d   = S_DISP;
				end
			end
			S_DISP: begin
				case (stat.cmd)
					lcbcl_pkg::CMD_INSERT: begin
						if (!stat.full) begin
							cmd.rd_bucket = 1'b1;
							state_d       = S_INS_WR;
						end else if (stat.out_free) begin
							cmd.finish = 1'b1;
							cmd.result = lcbcl_pkg::ST_FULL;
							state_d    = S_IDLE;
						end
					end
					lcbcl_pkg::CMD_LOOKUP: begin
						if (stat.used) begin
							cmd.rd_bucket = 1'b1;
							state_d       = S_LK_HD;
						end else if (stat.out_free) begin
							cmd.finish = 1'b1;
							cmd.result = lcbcl_pkg::ST_NOT_FOUND;
							state_d    = S_IDLE;
						end
					end
					lcbcl_pkg::CMD_CLEAR: begin
						if (stat.out_free) begin
							cmd.clr    = 1'b1;
							cmd.finish = 1'b1;
							cmd.result = lcbcl_pkg::ST_CLEARED;
							state_d    = S_IDLE;
						end
					end
					default: begin
						if (stat.out_free) begin
							cmd.finish = 1'b1;
							cmd.result = lcbcl_pkg::ST_NOT_FOUND;
							state_d    = S_IDLE;
						end
					end
				endcase
			end
			S_INS_WR: begin
				if (stat.out_free) begin
					cmd.ins_write = 1'b1;
					cmd.finish    = 1'b1;
					cmd.result    = lcbcl_pkg::ST_INSERTED;
					state_d       = S_IDLE;
				end
			end
			S_LK_HD: begin
				cmd.lk_start = 1'b1;
				state_d      = S_LK_CMP;
			end
			S_LK_CMP: begin
				if (stat.match || stat.last) begin
					if (stat.out_free) begin
						cmd.finish    = 1'b1;
						cmd.walk_done = 1'b1;
						cmd.result    = stat.match ? lcbcl_pkg::ST_FOUND
						                           : lcbcl_pkg::ST_NOT_FOUND;
						state_d       = S_IDLE;
					end
				end else begin
					cmd.lk_step = 1'b1;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Advance state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/lcbcl_dp.sv -----
// Datapath: key, link and bucket memories, chain walk registers and result register.
`default_nettype none

module lcbcl_dp (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire lcbcl_pkg::req_t    req,
	input  wire lcbcl_pkg::dp_cmd_t cmd,
	output lcbcl_pkg::dp_stat_t     stat,
	output logic                    rsp_valid,
	input  wire logic               rsp_ready,
	output lcbcl_pkg::rsp_t         rsp
);

	localparam int IDX_W = lcbcl_pkg::IDX_W;
	localparam int CNT_W = lcbcl_pkg::CNT_W;

	logic [1:0]                   cmd_q;
	logic [lcbcl_pkg::KEY_W-1:0]  key_q;
	logic [CNT_W-1:0]             count_q;
	logic [lcbcl_pkg::BUCKETS-1:0] used_q;
	logic [IDX_W-1:0]             cur_q;
	logic [IDX_W-1:0]             tail_q;
	logic [CNT_W-1:0]             probes_q;
	logic                         out_valid_q;
	lcbcl_pkg::rsp_t              out_q;

	logic [lcbcl_pkg::BKT_W-1:0]  bucket;
	logic [IDX_W-1:0]             slot;
	logic                         bkt_used;
	logic [2*IDX_W-1:0]           bkt_rdata;
	logic [2*IDX_W-1:0]           bkt_wdata;
	logic [IDX_W-1:0]             bkt_head;
	logic [IDX_W-1:0]             bkt_tail;
	logic [lcbcl_pkg::KEY_W-1:0]  key_rdata;
	logic [IDX_W-1:0]             link_rdata;
	logic                         walk_re;
	logic [IDX_W-1:0]             walk_addr;
	logic [CNT_W-1:0]             probes_nxt;
	logic                         out_free;

	assign bucket     = key_q[lcbcl_pkg::BKT_W-1:0];
	assign slot       = count_q[IDX_W-1:0];
	assign bkt_used   = used_q[bucket];
	assign bkt_head   = bkt_rdata[2*IDX_W-1:IDX_W];
	assign bkt_tail   = bkt_rdata[IDX_W-1:0];
	assign bkt_wdata  = {(bkt_used ? bkt_head : slot), slot};
	assign walk_re    = cmd.lk_start | cmd.lk_step;
	assign walk_addr  = cmd.lk_start ? bkt_head : link_rdata;
	assign probes_nxt = probes_q + CNT_W'(1);
	assign out_free   = !out_valid_q || rsp_ready;

	// Status back to the controller
	assign stat.cmd      = cmd_q;
	assign stat.full     = (count_q == CNT_W'(lcbcl_pkg::ENTRIES));
	assign stat.used     = bkt_used;
	assign stat.match    = (key_rdata == key_q);
	assign stat.last     = (cur_q == tail_q) || (probes_nxt == CNT_W'(lcbcl_pkg::ENTRIES));
	assign stat.out_free = out_free;

	// Head and tail of each bucket, packed as one word
	lcbcl_ram #(
		.WIDTH (2*IDX_W),
		.DEPTH (lcbcl_pkg::BUCKETS)
	) u_bkt_ram (
		.clk   (clk),
		.we    (cmd.ins_write),
		.waddr (bucket),
		.wdata (bkt_wdata),
		.re    (cmd.rd_bucket),
		.raddr (bucket),
		.rdata (bkt_rdata)
	);

	// Key of each entry
	lcbcl_ram #(
		.WIDTH (lcbcl_pkg::KEY_W),
		.DEPTH (lcbcl_pkg::ENTRIES)
	) u_key_ram (
		.clk   (clk),
		.we    (cmd.ins_write),
		.waddr (slot),
		.wdata (key_q),
		.re    (walk_re),
		.raddr (walk_addr),
		.rdata (key_rdata)
	);

	// Next entry in the same chain; link the old tail on insert
	lcbcl_ram #(
		.WIDTH (IDX_W),
		.DEPTH (lcbcl_pkg::ENTRIES)
	) u_link_ram (
		.clk   (clk),
		.we    (cmd.ins_write && bkt_used),
		.waddr (bkt_tail),
		.wdata (slot),
		.re    (walk_re),
		.raddr (walk_addr),
		.rdata (link_rdata)
	);

	// Hold the accepted item
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			cmd_q <= req.cmd;
			key_q <= req.key;
		end
	end

	// Walk registers: current entry, chain tail, probes so far
	always_ff @(posedge clk) begin
		if (cmd.lk_start) begin
			cur_q    <= bkt_head;
			tail_q   <= bkt_tail;
			probes_q <= '0;
		end else if (cmd.lk_step) begin
			cur_q    <= link_rdata;
			probes_q <= probes_nxt;
		end
	end

	// Fill count and bucket valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			used_q  <= '0;
		end else if (cmd.clr) begin
			count_q <= '0;
			used_q  <= '0;
		end else if (cmd.ins_write) begin
			count_q        <= count_q + CNT_W'(1);
			used_q[bucket] <= 1'b1;
		end
	end

	// Result valid: set on finish, drop on transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_q.status      <= cmd.result;
			out_q.entry_index <= '0;
			out_q.probe_count <= '0;
			if (cmd.result == lcbcl_pkg::ST_INSERTED) begin
				out_q.entry_index <= lcbcl_pkg::to_index8(slot);
			end else if (cmd.result == lcbcl_pkg::ST_FOUND) begin
				out_q.entry_index <= lcbcl_pkg::to_index8(cur_q);
			end
			if (cmd.walk_done) begin
				out_q.probe_count <= lcbcl_pkg::to_probe9(probes_nxt);
			end
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

endmodule

`default_nettype wire

// ----- hw/rtl/last_char_bucket_chained_lookup.sv -----
// Top level of the last-character chained lookup table.
// Requests arrive on req (cmd, key) with req_valid/req_ready; one result per
// request leaves on rsp (status, entry_index, probe_count) with rsp_valid/rsp_ready.
// A request is taken only while no other request is in progress; results come
// back in request order. Steps from transfer to result valid:
//   clear, table-full insert, empty-bucket lookup, unused command: finished at dispatch
//   insert: bucket head/tail read, then key, link and bucket writes
//   lookup: bucket head/tail read, then one key/link RAM read per entry visited
// A new request is taken only once the controller is back in idle, which it
// enters as the result is registered. The result sits in an output register:
// a stalled receiver does not block the next request, but the following
// result waits (holding its state) until the register is free.
// Reset clears the entry count and the 256 bucket valid bits at once; no
// clearing pass runs. A clear command does the same. Key and link memories
// are read only at entries written since the last clear.
`default_nettype none

module last_char_bucket_chained_lookup (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            req_valid,
	output logic                 req_ready,
	input  wire lcbcl_pkg::req_t req,
	output logic                 rsp_valid,
	input  wire logic            rsp_ready,
	output lcbcl_pkg::rsp_t      rsp
);

	lcbcl_pkg::dp_cmd_t  cmd;
	lcbcl_pkg::dp_stat_t stat;

	lcbcl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	lcbcl_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.stat      (stat),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule

`default_nettype wire
